>>> sv/kcl_pkg.sv
// Shared types and constants of the keypad code lock.
package kcl_pkg;

	localparam int SECRET_W = 12;
	localparam int MAX_CODE_LENGTH = 8;
	localparam int MAX_CODE_W = 2 * MAX_CODE_LENGTH;

	localparam logic [1:0] REQ_PRESS = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_DIGIT = 3'd1;
	localparam logic [2:0] EV_OPENED = 3'd2;
	localparam logic [2:0] EV_WRONG = 3'd3;
	localparam logic [2:0] EV_LOCKED = 3'd4;
	localparam logic [2:0] EV_LOCK_OVER = 3'd5;
	localparam logic [2:0] EV_CLOSED = 3'd6;

	localparam logic [1:0] CFG_SECRET_CODE = 2'd0;
	localparam logic [1:0] CFG_MAX_MISSES = 2'd1;
	localparam logic [1:0] CFG_LOCKOUT_TICKS = 2'd2;
	localparam logic [1:0] CFG_HOLD_TICKS = 2'd3;

	localparam logic [1:0] KEY_ONE = 2'd1;
	localparam logic [1:0] KEY_NONE = 2'd0;

	typedef enum logic [1:0] {
		MODE_CLOSED = 2'd0,
		MODE_OPEN = 2'd1,
		MODE_LOCKED = 2'd2
	} mode_t;

	typedef struct packed {
		logic [SECRET_W-1:0] secret_code;
		logic [3:0] max_misses;
		logic [7:0] lockout_ticks;
		logic [7:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic led_on;
		logic [2:0] digits_entered;
		mode_t lock_mode;
	} res_t;

endpackage

>>> sv/kcl_core.sv
// Lock state and its update for one request, computed combinationally and registered on step.
module kcl_core #(
	parameter int CODE_LENGTH = 6
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [1:0] req_type,
	input logic [1:0] key_digit,
	input kcl_pkg::cfg_t cfg,
	output kcl_pkg::res_t res
);
	import kcl_pkg::*;

	localparam int CNT_W = $clog2(CODE_LENGTH + 1);

	mode_t mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0] miss_q, miss_d;
	logic [7:0] left_q, left_d;
	logic [7:0] hold_q, hold_d;
	logic led_q, led_d;
	logic [1:0] digits_q [CODE_LENGTH];

	logic [MAX_CODE_W-1:0] code_pad;
	logic match;
	logic take;
	logic full;
	logic [3:0] miss_inc;
	logic lock_hit;
	logic release_close;
	logic lock_end;
	logic [2:0] event_code;

	assign code_pad = MAX_CODE_W'(cfg.secret_code);

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (CNT_W'(i) == cnt_q) begin
				match = match & (key_digit == code_pad[2*i +: 2]);
			end else begin
				match = match & (digits_q[i] == code_pad[2*i +: 2]);
			end
		end
	end

	assign take = (req_type == REQ_PRESS) && (key_digit != KEY_NONE)
		&& (mode_q == MODE_CLOSED) && (cnt_q < CNT_W'(CODE_LENGTH));
	assign full = take && (cnt_q == CNT_W'(CODE_LENGTH - 1));
	assign miss_inc = miss_q + 4'd1;
	assign lock_hit = !match && (miss_inc >= cfg.max_misses);
	assign release_close = (req_type == REQ_RELEASE) && (mode_q == MODE_OPEN)
		&& (hold_q > cfg.hold_ticks);
	assign lock_end = (req_type == REQ_TICK) && (mode_q == MODE_LOCKED) && (left_q <= 8'd1);

	// Next state.
	always_comb begin
		mode_d = mode_q;
		cnt_d = cnt_q;
		miss_d = miss_q;
		left_d = left_q;
		hold_d = hold_q;
		led_d = led_q;
		unique case (req_type)
			REQ_PRESS: begin
				if (take) begin
					cnt_d = cnt_q + CNT_W'(1);
					if (full) begin
						if (match) begin
							mode_d = MODE_OPEN;
							miss_d = 4'd0;
							hold_d = 8'd0;
							led_d = 1'b1;
						end else if (lock_hit) begin
							mode_d = MODE_LOCKED;
							left_d = cfg.lockout_ticks;
							miss_d = 4'd0;
						end else begin
							miss_d = miss_inc;
							cnt_d = '0;
						end
					end
				end else if (mode_q == MODE_OPEN && key_digit == KEY_ONE) begin
					hold_d = 8'd0;
				end
			end
			REQ_RELEASE: begin
				if (release_close) begin
					mode_d = MODE_CLOSED;
					hold_d = 8'd0;
					cnt_d = '0;
					led_d = 1'b0;
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_LOCKED) begin
					if (lock_end) begin
						left_d = 8'd0;
						mode_d = MODE_CLOSED;
						cnt_d = '0;
						led_d = 1'b0;
					end else begin
						left_d = left_q - 8'd1;
						led_d = !led_q;
					end
				end else if (mode_q == MODE_OPEN && hold_q != 8'hFF) begin
					hold_d = hold_q + 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Outputs.
	always_comb begin
		event_code = EV_NONE;
		if (full) begin
			if (match) begin
				event_code = EV_OPENED;
			end else if (lock_hit) begin
				event_code = EV_LOCKED;
			end else begin
				event_code = EV_WRONG;
			end
		end else if (take) begin
			event_code = EV_DIGIT;
		end else if (release_close) begin
			event_code = EV_CLOSED;
		end else if (lock_end) begin
			event_code = EV_LOCK_OVER;
		end
		res.event_code = event_code;
		res.led_on = led_d;
		res.digits_entered = 3'(cnt_d);
		res.lock_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CLOSED;
			cnt_q <= '0;
			miss_q <= 4'd0;
			left_q <= 8'd0;
			hold_q <= 8'd0;
			led_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			cnt_q <= cnt_d;
			miss_q <= miss_d;
			left_q <= left_d;
			hold_q <= hold_d;
			led_q <= led_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (step && take && cnt_q == CNT_W'(i)) begin
				digits_q[i] <= key_digit;
			end
		end
	end

endmodule

>>> sv/keypad_code_lock_with_lockout.sv
// Top level of the keypad code lock: stream ports, configuration registers, stage registers.
// Every request (key press, release of key 1, or tick) gives exactly one result: the request
// is held in the input register and its result in the result register, and a new request can
// be taken in every cycle while the output side is ready; the lock state is updated once per
// request between the input register and the result register. Configuration, written
// through cfg_we, cfg_addr and cfg_wdata, applies to requests processed after the write.
module keypad_code_lock_with_lockout #(
	parameter int CODE_LENGTH = 6
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,   // [1:0] key_digit, [7:2] zero
	input logic [1:0] s_tuser,   // [1:0] req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // [1:0] lock_mode, [4:2] digits_entered, [5] led_on,
	                             // [8:6] event_code, [15:9] zero
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [kcl_pkg::SECRET_W-1:0] cfg_wdata
);
	import kcl_pkg::*;

	cfg_t cfg_q;
	logic vld_s1;
	logic [1:0] req_s1;
	logic [1:0] key_s1;
	logic out_vld_q;
	res_t out_res_q;
	res_t res;
	logic advance;
	logic step;

	assign advance = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign step = vld_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secret_code <= 12'd1957;
			cfg_q.max_misses <= 4'd2;
			cfg_q.lockout_ticks <= 8'd50;
			cfg_q.hold_ticks <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SECRET_CODE: cfg_q.secret_code <= cfg_wdata;
				CFG_MAX_MISSES: cfg_q.max_misses <= cfg_wdata[3:0];
				CFG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= cfg_wdata[7:0];
				CFG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= s_tuser;
			key_s1 <= s_tdata[1:0];
		end
		if (step) begin
			out_res_q <= res;
		end
	end

	kcl_core #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.req_type(req_s1),
		.key_digit(key_s1),
		.cfg(cfg_q),
		.res(res)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata = {7'd0, out_res_q.event_code, out_res_q.led_on,
		out_res_q.digits_entered, out_res_q.lock_mode};

endmodule
